### hw/rtl/cls_pkg.sv
// Shared types and character codes for the command line argument splitter.
`default_nettype none

package cls_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NUL       = 8'h00;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_END_ARG  = 2'd1;
    localparam logic [1:0] KIND_END_LINE = 2'd2;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
    } t_res;

    typedef struct packed {
        logic [1:0]           cnt;
        t_res [MAX_RES-1:0]   ent;
    } t_group;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [7:0] out_byte);
        t_res r;
        r.kind     = kind;
        r.out_byte = out_byte;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/command_line_arg_splitter.sv
// Top level of the command line argument splitter.
//
// Input channel: i_valid / o_ready carry one request per byte of a command
// line (i_char_byte), or a line end (i_end_of_line, byte ignored). A zero
// byte also ends the line.
// Output channel: o_valid / i_ready carry results: o_kind 0 = argument byte
// (o_out_byte), 1 = end of argument, 2 = end of line; o_last marks the final
// result of a request.
// A request passes the input register, then the result register, before its
// first result is offered; it waits in the input register while the result
// register cannot load. Throughput: one request per cycle while each yields
// at most one result and i_ready is high; a request yielding several results
// holds the input until all but its last result are taken, as the result
// register drains one result a cycle while i_ready is high.
// Reset clears the quote, escape and argument flags and empties both
// registers. When the receiver stalls the pending results hold and the input
// register keeps at most one further request before o_ready drops.
`default_nettype none

module command_line_arg_splitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_end_of_line,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_last
);
    import cls_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eol;
    logic       can_load;
    logic       adv;
    t_group     grp;

    assign adv     = r_in_valid && can_load;
    assign o_ready = !r_in_valid || can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_char_byte;
            r_eol  <= i_end_of_line;
        end
    end

    cls_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_byte),
        .i_eol   (r_eol),
        .o_grp   (grp)
    );

    cls_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_grp      (grp),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

### hw/rtl/cls_decode.sv
// Tokeniser state flags and the per-byte decode into a group of results.
`default_nettype none

module cls_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eol,
    output cls_pkg::t_group      o_grp
);
    import cls_pkg::*;

    logic r_started, r_in_quote, r_esc, r_nonempty;
    logic n_started, n_in_quote, n_esc, n_nonempty;
    t_group g;

    always_comb begin
        n_started  = r_started;
        n_in_quote = r_in_quote;
        n_esc      = r_esc;
        n_nonempty = r_nonempty;
        g          = '0;
        if (i_eol || i_byte == CH_NUL) begin
            if (r_esc) begin
                g.ent[0] = mk_res(KIND_BYTE, CH_BACKSLASH);
                g.ent[1] = mk_res(KIND_END_ARG, CH_NUL);
                g.ent[2] = mk_res(KIND_END_LINE, CH_NUL);
                g.cnt    = 2'd3;
            end else if (r_nonempty) begin
                g.ent[0] = mk_res(KIND_END_ARG, CH_NUL);
                g.ent[1] = mk_res(KIND_END_LINE, CH_NUL);
                g.cnt    = 2'd2;
            end else begin
                g.ent[0] = mk_res(KIND_END_LINE, CH_NUL);
                g.cnt    = 2'd1;
            end
            n_started  = 1'b0;
            n_in_quote = 1'b0;
            n_esc      = 1'b0;
            n_nonempty = 1'b0;
        end else if (r_esc) begin
            n_esc      = 1'b0;
            n_nonempty = 1'b1;
            if (i_byte inside {CH_SPACE, CH_BACKSLASH, CH_QUOTE}) begin
                g.ent[0] = mk_res(KIND_BYTE, i_byte);
                g.cnt    = 2'd1;
            end else begin
                n_started = 1'b1;
                g.ent[0]  = mk_res(KIND_BYTE, CH_BACKSLASH);
                g.ent[1]  = mk_res(KIND_BYTE, i_byte);
                g.cnt     = 2'd2;
            end
        end else if (!r_started && i_byte == CH_SPACE) begin
            n_started = 1'b0;
        end else begin
            n_started = 1'b1;
            case (i_byte)
                CH_BACKSLASH: begin
                    n_esc = 1'b1;
                end
                CH_QUOTE: begin
                    n_in_quote = !r_in_quote;
                    if (r_in_quote || r_nonempty) begin
                        g.ent[0]   = mk_res(KIND_END_ARG, CH_NUL);
                        g.cnt      = 2'd1;
                        n_started  = 1'b0;
                        n_nonempty = 1'b0;
                    end
                end
                CH_SPACE: begin
                    if (r_in_quote) begin
                        g.ent[0]   = mk_res(KIND_BYTE, CH_SPACE);
                        g.cnt      = 2'd1;
                        n_nonempty = 1'b1;
                    end else begin
                        g.ent[0]   = mk_res(KIND_END_ARG, CH_NUL);
                        g.cnt      = 2'd1;
                        n_started  = 1'b0;
                        n_nonempty = 1'b0;
                    end
                end
                default: begin
                    g.ent[0]   = mk_res(KIND_BYTE, i_byte);
                    g.cnt      = 2'd1;
                    n_nonempty = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_in_quote <= 1'b0;
            r_esc      <= 1'b0;
            r_nonempty <= 1'b0;
        end else if (i_adv) begin
            r_started  <= n_started;
            r_in_quote <= n_in_quote;
            r_esc      <= n_esc;
            r_nonempty <= n_nonempty;
        end
    end

    assign o_grp = g;

    a_esc_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> r_started)
        else $error("escape pending without a started argument");

    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_eol) |-> (g.cnt != 2'd0 && g.ent[g.cnt - 2'd1].kind == KIND_END_LINE))
        else $error("line end request without a closing line mark");

    a_eol_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_eol) |=> (!r_started && !r_in_quote && !r_esc && !r_nonempty))
        else $error("state not cleared after line end");

endmodule

`default_nettype wire

### hw/rtl/cls_obuf.sv
// Result register for one group of results, drained one per cycle on i_ready.
`default_nettype none

module cls_obuf (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire cls_pkg::t_group i_grp,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [1:0]           o_kind,
    output logic [7:0]           o_out_byte,
    output logic                 o_last
);
    import cls_pkg::*;

    logic [1:0]         r_cnt;
    t_res [MAX_RES-1:0] r_ent;
    logic               take;

    assign take       = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_grp.ent;
        end else if (take) begin
            r_ent <= {mk_res(KIND_BYTE, CH_NUL), r_ent[MAX_RES-1:1]};
        end
    end

    assign o_valid    = (r_cnt != 2'd0);
    assign o_kind     = r_ent[0].kind;
    assign o_out_byte = r_ent[0].out_byte;
    assign o_last     = (r_cnt == 2'd1);

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_cnt != 2'd0) |-> (r_cnt == 2'd1 && i_ready))
        else $error("group loaded over undelivered results");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_load && r_cnt != 2'd1) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result count did not step down");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_cnt == $past(r_cnt) && $stable(r_ent)))
        else $error("stalled results changed");

endmodule

`default_nettype wire

### test/command_line_arg_splitter_checker.sv
// Watches both channels of the argument splitter, predicts each result and compares it.
`timescale 1ns / 100ps

module command_line_arg_splitter_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire logic       i_req_ready,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_end_of_line,
    input  wire logic       i_res_valid,
    input  wire logic       i_res_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_last,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    import cls_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_arg_token;

    t_arg_token expected_tokens[$];
    t_arg_token want;

    logic in_arg;
    logic in_quotes;
    logic escape_held;
    logic arg_has_bytes;

    int mismatch_count = 0;
    int tokens_checked = 0;

    task automatic push_token(input logic [1:0] kind, input logic [7:0] out_byte);
        t_arg_token tok;
        tok.kind     = kind;
        tok.out_byte = out_byte;
        tok.last     = 1'b0;
        expected_tokens.push_back(tok);
    endtask

    task automatic close_argument();
        push_token(KIND_END_ARG, 8'h00);
        arg_has_bytes = 1'b0;
        in_arg        = 1'b0;
    endtask

    task automatic predict_tokens(input logic [7:0] b, input logic eol);
        int         size_before;
        logic       done;
        t_arg_token tok;
        size_before = expected_tokens.size();
        done        = 1'b0;
        if (eol || b == CH_NUL) begin
            if (escape_held) begin
                push_token(KIND_BYTE, CH_BACKSLASH);
                arg_has_bytes = 1'b1;
            end
            if (arg_has_bytes) begin
                push_token(KIND_END_ARG, 8'h00);
            end
            push_token(KIND_END_LINE, 8'h00);
            in_arg        = 1'b0;
            in_quotes     = 1'b0;
            escape_held   = 1'b0;
            arg_has_bytes = 1'b0;
        end else begin
            if (escape_held) begin
                escape_held   = 1'b0;
                arg_has_bytes = 1'b1;
                if (b == CH_SPACE || b == CH_BACKSLASH || b == CH_QUOTE) begin
                    push_token(KIND_BYTE, b);
                    done = 1'b1;
                end else begin
                    push_token(KIND_BYTE, CH_BACKSLASH);
                end
            end
            if (!done) begin
                if (!in_arg && b == CH_SPACE) begin
                    done = 1'b1;
                end else begin
                    in_arg = 1'b1;
                end
            end
            if (!done) begin
                if (b == CH_BACKSLASH) begin
                    escape_held = 1'b1;
                end else if (b == CH_QUOTE) begin
                    if (!in_quotes) begin
                        in_quotes = 1'b1;
                        if (arg_has_bytes) begin
                            close_argument();
                        end
                    end else begin
                        in_quotes = 1'b0;
                        close_argument();
                    end
                end else if (b == CH_SPACE && !in_quotes) begin
                    close_argument();
                end else begin
                    push_token(KIND_BYTE, b);
                    arg_has_bytes = 1'b1;
                end
            end
        end
        if (expected_tokens.size() > size_before) begin
            tok      = expected_tokens.pop_back();
            tok.last = 1'b1;
            expected_tokens.push_back(tok);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_arg        = 1'b0;
            in_quotes     = 1'b0;
            escape_held   = 1'b0;
            arg_has_bytes = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_tokens.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: kind %0d byte %02h last %0b",
                                 i_kind, i_out_byte, i_last);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    tokens_checked++;
                    if (i_kind !== want.kind || i_out_byte !== want.out_byte
                            || i_last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                                     tokens_checked, want.kind, want.out_byte, want.last,
                                     i_kind, i_out_byte, i_last);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predict_tokens(i_char_byte, i_end_of_line);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_tokens.size();
        o_checked    <= tokens_checked;
    end

endmodule

### test/command_line_arg_splitter_tb.sv
// Stimulus and verdict for the command line argument splitter.
`timescale 1ns / 100ps

module command_line_arg_splitter_tb;
    import cls_pkg::*;

    localparam int RANDOM_REQUESTS = 95;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_char_byte   = 8'h00;
    logic       i_end_of_line = 1'b0;
    logic       i_ready       = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_last;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count   = 0;
    int requests_sent = 0;
    int lines_sent    = 0;
    int stall_left    = 0;
    logic steady_send = 1'b0;
    logic steady_recv = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    command_line_arg_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_byte   (i_char_byte),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

    command_line_arg_splitter_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_char_byte   (i_char_byte),
        .i_end_of_line (i_end_of_line),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_kind        (o_kind),
        .i_out_byte    (o_out_byte),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (checked_count)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        while (b == CH_SPACE || b == CH_QUOTE || b == CH_BACKSLASH) begin
            b = 8'($urandom_range(1, 255));
        end
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_QUOTE;
            2: return CH_BACKSLASH;
            3: return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count % 200 == 0) begin
            steady_recv <= ($urandom_range(0, 3) == 0);
        end
        if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (!steady_recv && $urandom_range(0, 3) == 0) begin
                stall_left <= gap_length();
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic eol);
        int gap;
        i_valid       <= 1'b1;
        i_char_byte   <= b;
        i_end_of_line <= eol;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        requests_sent++;
        if (eol || b == CH_NUL) begin
            lines_sent++;
        end
        gap = steady_send ? 0 : gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], 1'b0);
        end
    endtask

    task automatic send_random_line();
        int tokens;
        tokens = $urandom_range(1, 4);
        repeat ($urandom_range(0, 2)) send_request(CH_SPACE, 1'b0);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) send_request(plain_byte(), 1'b0);
                end
                2: begin
                    send_request(CH_QUOTE, 1'b0);
                    repeat ($urandom_range(0, 4)) begin
                        send_request(($urandom_range(0, 2) == 0) ? CH_SPACE : plain_byte(),
                                     1'b0);
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        send_request(CH_QUOTE, 1'b0);
                    end
                end
                default: begin
                    send_request(CH_BACKSLASH, 1'b0);
                    if ($urandom_range(0, 3) != 0) begin
                        send_request(noise_byte() == CH_NUL ? plain_byte() : noise_byte(),
                                     1'b0);
                    end
                end
            endcase
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 2)) send_request(CH_SPACE, 1'b0);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_request(CH_NUL, 1'b0);
        end else begin
            send_request(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int random_start;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(8'h00, 1'b1);

        send_text(" a\" b\"\"\"");
        send_request(8'h41, 1'b1);

        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_SPACE, 1'b0);
        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request(CH_BACKSLASH, 1'b0);
        send_request(8'h78, 1'b0);
        send_request(CH_BACKSLASH, 1'b0);
        send_request(CH_NUL, 1'b0);

        send_request(8'hFF, 1'b0);
        send_request(CH_SPACE, 1'b0);
        send_request(CH_QUOTE, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(CH_NUL, 1'b1);

        random_start = requests_sent;
        while (requests_sent - random_start < RANDOM_REQUESTS) begin
            steady_send = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) send_request(noise_byte(), 1'b0);
                send_request(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                send_random_line();
            end
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests over %0d lines; %0d results compared.",
                 requests_sent, lines_sent, checked_count);
        $display("Covered escapes, quoting, leading spaces and line ends under random stalls.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/cls_pkg.sv
hw/rtl/cls_decode.sv
hw/rtl/cls_obuf.sv
hw/rtl/command_line_arg_splitter.sv
test/command_line_arg_splitter_checker.sv
test/command_line_arg_splitter_tb.sv
